// ===== rtl/packet_impairment_scheduler_defines.svh =====
// Assertion macros for the impairment scheduler RTL (used by pis_back).
// Depends on a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef PACKET_IMPAIRMENT_SCHEDULER_DEFINES_SVH
`define PACKET_IMPAIRMENT_SCHEDULER_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define PIS_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define PIS_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pis_pkg.sv =====
// Types, constants and helpers for the packet impairment scheduler.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package pis_pkg;

    localparam logic [29:0] NS_PER_S  = 30'd1000000000;
    localparam logic [19:0] NS_PER_MS = 20'd1000000;
    localparam int          NUM_W     = 47;
    localparam int          DIV_STEPS = NUM_W;

    localparam int FX_DROP     = 0;
    localparam int FX_BURST    = 1;
    localparam int FX_DUP      = 2;
    localparam int FX_DELAY    = 3;
    localparam int FX_JITTER   = 4;
    localparam int FX_THROTTLE = 5;

    typedef enum logic [3:0] {
        REG_LOSS_RATE    = 4'd0,
        REG_BURST_RATE   = 4'd1,
        REG_BURST_LENGTH = 4'd2,
        REG_COPY_EXTRA   = 4'd3,
        REG_COPY_RATE    = 4'd4,
        REG_BASE_DELAY   = 4'd5,
        REG_JITTER       = 4'd6,
        REG_BYTE_RATE    = 4'd7
    } reg_idx_t;

    typedef struct packed {
        logic [16:0] loss_rate;
        logic [16:0] burst_rate;
        logic [15:0] burst_length;
        logic [3:0]  copy_extra;
        logic [16:0] copy_rate;
        logic [15:0] base_delay_ms;
        logic [15:0] jitter_max_ms;
        logic [31:0] byte_rate;
    } cfg_t;

    typedef struct packed {
        logic [15:0] frame_bytes;
        logic [63:0] now_ns;
        logic [15:0] loss_pick;
        logic [15:0] copy_pick;
        logic [15:0] jitter_pick;
    } in_item_t;

    typedef struct packed {
        logic        dropped;
        logic [63:0] release_ns;
        logic        send_now;
        logic [5:0]  effects;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic        dropped;
        logic [5:0]  effects;
        logic [3:0]  extra;
        logic [15:0] bytes;
        logic [63:0] now;
        logic [63:0] base_rel;
    } job_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DLY,
        F_SUM,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_LOAD,
        B_DIV,
        B_COPY,
        B_EMIT
    } back_state_t;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            return s[64] ? '1 : s[63:0];
        end
    endfunction

endpackage

// ===== rtl/pis_queue.sv =====
// Two-entry job queue between the classifier and the scheduler back end.
// Depends on pis_pkg for the job type.
`timescale 1ns / 1ps
module pis_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  pis_pkg::job_t in_job,
    output logic          out_valid,
    input  logic          out_ready,
    output pis_pkg::job_t out_job
);
    import pis_pkg::*;

    job_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_job   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_job;
    end

endmodule

// ===== rtl/pis_front.sv =====
// Front end: accepts packets, decides loss and duplication, computes the base release time.
// Depends on pis_pkg.
`timescale 1ns / 1ps
module pis_front #(
    parameter int MAX_EXTRA_COPIES = 15
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pis_pkg::cfg_t     cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  pis_pkg::in_item_t in_item,
    output logic              job_valid,
    input  logic              job_ready,
    output pis_pkg::job_t     job
);
    import pis_pkg::*;

    front_state_t st_reg, st_next;
    logic [15:0]  burst_left_reg, burst_left_next;
    job_t         job_reg;
    logic [16:0]  jit_reg;
    logic [36:0]  dly_ns_reg;

    logic        burst_on, cont, start, rnd, lost, dup, accept;
    logic [3:0]  extra;
    logic [5:0]  fx;
    logic [32:0] jit_prod;
    logic [16:0] delay_ms;

    assign accept = in_valid && in_ready;
    assign job    = job_reg;

    always_comb
    begin
        burst_on = (cfg.burst_length != 16'd0);
        cont     = burst_on && (burst_left_reg != 16'd0);
        start    = burst_on && !cont && ({1'b0, in_item.loss_pick} < cfg.burst_rate);
        rnd      = !burst_on && ({1'b0, in_item.loss_pick} < cfg.loss_rate);
        lost     = cont || start || rnd;
        dup      = (cfg.copy_extra != 4'd0) && ({1'b0, in_item.copy_pick} < cfg.copy_rate);
        if ({28'd0, cfg.copy_extra} > MAX_EXTRA_COPIES)
            extra = 4'(MAX_EXTRA_COPIES);
        else
            extra = cfg.copy_extra;
        fx = 6'd0;
        if (lost)
        begin
            fx[FX_DROP]  = 1'b1;
            fx[FX_BURST] = burst_on;
        end
        else
        begin
            fx[FX_DUP]    = dup;
            fx[FX_DELAY]  = (cfg.base_delay_ms != 16'd0);
            fx[FX_JITTER] = (cfg.jitter_max_ms != 16'd0);
        end
        if (!burst_on)
            burst_left_next = 16'd0;
        else if (cont)
            burst_left_next = burst_left_reg - 16'd1;
        else if (start)
            burst_left_next = cfg.burst_length - 16'd1;
        else
            burst_left_next = burst_left_reg;
        jit_prod = 33'(in_item.jitter_pick) * 33'({1'b0, cfg.jitter_max_ms} + 17'd1);
        delay_ms = 17'(cfg.base_delay_ms) + jit_reg;
    end

    always_comb
    begin
        st_next   = st_reg;
        in_ready  = 1'b0;
        job_valid = 1'b0;
        case (st_reg)
            F_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    st_next = lost ? F_PUSH : F_DLY;
            end
            F_DLY:
                st_next = F_SUM;
            F_SUM:
                st_next = F_PUSH;
            F_PUSH:
            begin
                job_valid = 1'b1;
                if (job_ready)
                    st_next = F_IDLE;
            end
            default:
                st_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= F_IDLE;
            burst_left_reg <= 16'd0;
        end
        else
        begin
            st_reg <= st_next;
            if (accept)
                burst_left_reg <= burst_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg.dropped  <= lost;
            job_reg.effects  <= fx;
            job_reg.extra    <= dup ? extra : 4'd0;
            job_reg.bytes    <= in_item.frame_bytes;
            job_reg.now      <= in_item.now_ns;
            job_reg.base_rel <= 64'd0;
            jit_reg          <= jit_prod[32:16];
        end
        if (st_reg == F_DLY)
            dly_ns_reg <= 37'(delay_ms) * 37'(NS_PER_MS);
        if (st_reg == F_SUM)
            job_reg.base_rel <= sat_add(job_reg.now, 64'(dly_ns_reg));
    end

endmodule

// ===== rtl/pis_back.sv =====
// Back end: transmit-time divider, per-copy throttle scheduling and result output register.
// Depends on pis_pkg and the assertion macro header.
`timescale 1ns / 1ps
module pis_back #(
    parameter int MAX_EXTRA_COPIES = 15
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pis_pkg::cfg_t      cfg,
    input  logic               nf_clear,
    input  logic               job_valid,
    output logic               job_ready,
    input  pis_pkg::job_t      job,
    output logic               out_valid,
    input  logic               out_ready,
    output pis_pkg::out_item_t out_item
);
    import pis_pkg::*;
    `include "packet_impairment_scheduler_defines.svh"

    localparam int DEPTH = ((MAX_EXTRA_COPIES < 15) ? MAX_EXTRA_COPIES : 15) + 1;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int STP_W = $clog2(DIV_STEPS);

    back_state_t      st_reg, st_next;
    job_t             job_reg;
    logic [63:0]      nf_reg;
    logic [63:0]      tr_reg;
    logic             held_reg;
    logic             div_used_reg;
    logic [45:0]      prod_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [31:0]      rem_reg;
    logic [STP_W-1:0] step_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [63:0]      buf_mem [DEPTH];
    logic             out_valid_reg;
    out_item_t        out_reg;

    logic        thr, pop, emit_go, idx_last, hold_back;
    logic [32:0] div_t;
    logic        div_ge;
    logic [63:0] tx, r_copy, tr_after;

    assign thr       = (cfg.byte_rate != 32'd0);
    assign pop       = job_valid && job_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;
    assign idx_last  = (4'(idx_reg) == job_reg.extra);

    always_comb
    begin
        div_t     = {rem_reg, quo_reg[NUM_W-1]};
        div_ge    = (div_t >= {1'b0, cfg.byte_rate});
        if (!div_used_reg)
            tx = 64'd0;
        else if (quo_reg == '0)
            tx = 64'd1;
        else
            tx = 64'(quo_reg);
        hold_back = thr && (tr_reg > job_reg.base_rel);
        r_copy    = hold_back ? tr_reg : job_reg.base_rel;
        tr_after  = sat_add(r_copy, tx);
    end

    always_comb
    begin
        st_next   = st_reg;
        job_ready = 1'b0;
        emit_go   = 1'b0;
        case (st_reg)
            B_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    if (job.dropped)
                        st_next = B_EMIT;
                    else if (thr && job.bytes != 16'd0)
                        st_next = B_MUL;
                    else
                        st_next = B_COPY;
                end
            end
            B_MUL:
                st_next = B_LOAD;
            B_LOAD:
                st_next = B_DIV;
            B_DIV:
                if (step_reg == STP_W'(DIV_STEPS - 1))
                    st_next = B_COPY;
            B_COPY:
                if (idx_last)
                    st_next = B_EMIT;
            B_EMIT:
            begin
                emit_go = !out_valid_reg || out_ready;
                if (emit_go && (job_reg.dropped || idx_last))
                    st_next = B_IDLE;
            end
            default:
                st_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= B_IDLE;
            nf_reg        <= 64'd0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (nf_clear)
                nf_reg <= 64'd0;
            else if (st_reg == B_COPY && idx_last && thr)
                nf_reg <= tr_after;
            if (emit_go)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            // advance the copy index through compute, then again through output
            if (pop)
                idx_reg <= '0;
            else if (st_reg == B_COPY)
                idx_reg <= idx_last ? '0 : idx_reg + 1'b1;
            else if (emit_go)
                idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg      <= job;
            tr_reg       <= (nf_reg < job.now) ? job.now : nf_reg;
            held_reg     <= 1'b0;
            div_used_reg <= thr && (job.bytes != 16'd0);
        end
        if (st_reg == B_MUL)
            prod_reg <= 46'(job_reg.bytes) * 46'(NS_PER_S);
        if (st_reg == B_LOAD)
        begin
            quo_reg  <= NUM_W'(prod_reg) + NUM_W'(cfg.byte_rate) - NUM_W'(1);
            rem_reg  <= 32'd0;
            step_reg <= '0;
        end
        if (st_reg == B_DIV)
        begin
            rem_reg  <= div_ge ? 32'(div_t - {1'b0, cfg.byte_rate}) : div_t[31:0];
            quo_reg  <= {quo_reg[NUM_W-2:0], div_ge};
            step_reg <= step_reg + 1'b1;
        end
        if (st_reg == B_COPY)
        begin
            buf_mem[idx_reg] <= r_copy;
            tr_reg           <= tr_after;
            held_reg         <= held_reg || hold_back;
        end
        if (emit_go)
        begin
            out_reg.dropped    <= job_reg.dropped;
            out_reg.release_ns <= job_reg.dropped ? 64'd0 : buf_mem[idx_reg];
            out_reg.send_now   <= !job_reg.dropped && (buf_mem[idx_reg] <= job_reg.now);
            out_reg.effects    <= job_reg.effects | {held_reg && thr, 5'd0};
            out_reg.last       <= job_reg.dropped || idx_last;
        end
    end

    `PIS_ASSERT_IMP(a_drop_single, out_valid && out_item.dropped, out_item.last && out_item.release_ns == 64'd0, "dropped result must be single and carry no time")
    `PIS_ASSERT_IMP(a_div_rate, st_reg == B_DIV, cfg.byte_rate != 32'd0, "divider running with zero rate")
    `PIS_ASSERT_NXT(a_copy_flow, st_reg == B_COPY, st_reg == B_COPY || st_reg == B_EMIT, "copy phase left early")

endmodule

// ===== rtl/packet_impairment_scheduler.sv =====
// Top level of the packet impairment scheduler: configuration registers and the front/back split.
// Depends on pis_pkg, pis_front, pis_queue and pis_back.
`timescale 1ns / 1ps
// Each accepted packet word produces one result word when it is lost (random or burst loss),
// otherwise one to MAX_EXTRA_COPIES+1 result words (at most 16), each with the release time
// of one copy; every result carries the full effect set and the final one has last set.
// The front end passes a lost packet from idle straight to its push state and any other
// through the delay and sum states, and hands it to a two-entry queue. The back end takes a
// job, and when the throttle is on and the frame has bytes it runs a multiply and a load
// state and then a radix-2 restoring divider of 47 steps for the transmit time. It then
// schedules the copies for the throttle and passes them one by one through the output
// register. The back end takes the next job only after the last result of the current one
// has gone to the output register. Configuration is written with cfg_we/cfg_index/cfg_data;
// the user must do so only while idle, which the block does not enforce; writing a new
// byte_rate value clears the throttle's next-free time.
module packet_impairment_scheduler #(
    parameter int MAX_EXTRA_COPIES = 15
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pis_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output pis_pkg::out_item_t out_item,
    input  logic               cfg_we,
    input  logic [3:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import pis_pkg::*;

    cfg_t cfg_reg;
    logic nf_clear;
    logic fq_valid, fq_ready;
    job_t fq_job;
    logic qb_valid, qb_ready;
    job_t qb_job;

    // clear throttle time only on a real change of byte rate
    assign nf_clear = cfg_we && (cfg_index == REG_BYTE_RATE) && (cfg_data != cfg_reg.byte_rate);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LOSS_RATE:    cfg_reg.loss_rate     <= cfg_data[16:0];
                REG_BURST_RATE:   cfg_reg.burst_rate    <= cfg_data[16:0];
                REG_BURST_LENGTH: cfg_reg.burst_length  <= cfg_data[15:0];
                REG_COPY_EXTRA:   cfg_reg.copy_extra    <= cfg_data[3:0];
                REG_COPY_RATE:    cfg_reg.copy_rate     <= cfg_data[16:0];
                REG_BASE_DELAY:   cfg_reg.base_delay_ms <= cfg_data[15:0];
                REG_JITTER:       cfg_reg.jitter_max_ms <= cfg_data[15:0];
                REG_BYTE_RATE:    cfg_reg.byte_rate     <= cfg_data;
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    // classify and time-stamp the packet
    pis_front #(.MAX_EXTRA_COPIES(MAX_EXTRA_COPIES)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job       (fq_job)
    );

    // decouple classification from scheduling
    pis_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_job    (fq_job),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_job   (qb_job)
    );

    // divide, throttle and emit the copies
    pis_back #(.MAX_EXTRA_COPIES(MAX_EXTRA_COPIES)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .nf_clear  (nf_clear),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job       (qb_job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule
